FILE: rtl/core/clpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_pkg
// Shared widths, codes and helpers of the cluster power election block.
// ----------------------------------------------------------------------------
package clpe_pkg;

    // payload widths
    localparam int OP_W   = 2;
    localparam int CORE_W = 2;
    localparam int IDX_W  = 3;
    localparam int TIME_W = 48;
    localparam int SID_W  = 32;
    localparam int RES_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // StateID affinity field
    localparam int         AFF_SHIFT = 24;
    localparam logic [1:0] AFF_MASK  = 2'h3;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_ENTER   = 2'd0,
        OP_EXIT    = 2'd1,
        OP_IPI_SET = 2'd2,
        OP_IPI_CLR = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONLINE_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_ID_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_ID_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_ID_3     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_ID_4     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDENCY      = 3'd6;

    // a StateID with nonzero affinity bits powers down the cluster
    function automatic logic is_cluster_id(input logic [SID_W-1:0] sid);
        return (sid[AFF_SHIFT +: 2] & AFF_MASK) != 2'b00;
    endfunction

endpackage

FILE: rtl/core/clpe_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_req_if
// Event channel: enter, exit and IPI events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clpe_req_if;
    logic                          valid;
    logic                          ready;
    clpe_pkg::t_op                 op;
    logic [clpe_pkg::CORE_W-1:0]   core;
    logic [clpe_pkg::IDX_W-1:0]    state_index;
    logic [clpe_pkg::TIME_W-1:0]   now_us;
    logic [clpe_pkg::TIME_W-1:0]   next_wake_us;

    modport source (output valid, op, core, state_index, now_us, next_wake_us,
                    input ready);
    modport sink   (input valid, op, core, state_index, now_us, next_wake_us,
                    output ready);
endinterface

FILE: rtl/core/clpe_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpe_rsp_if
// Grant channel: granted idle index and StateID with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clpe_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [clpe_pkg::IDX_W-1:0]   granted_index;
    logic [clpe_pkg::SID_W-1:0]   suspend_param;
    logic                         demoted;

    modport source (output valid, granted_index, suspend_param, demoted,
                    input ready);
    modport sink   (input valid, granted_index, suspend_param, demoted,
                    output ready);
endinterface

FILE: rtl/core/cluster_last_core_power_election_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_last_core_power_election_unit
// Idle-entry election of one cluster: grants or demotes cluster power states.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries core events. Exit and IPI events update the idle and
//   pending flags at the transfer and give no result.
//   An enter event gives one result on o_rsp: granted index, its StateID
//   and the demotion flag. Above index 0 it also marks the core idle and
//   stores its wake time; a WFI entry (index 0) skips the scan.
//   Any other entry walks all core slots one per cycle, then runs the time
//   gap in two more passes through the same 50-bit subtractor. Events for
//   a core at or above CORES are dropped without a result. i_req.ready is
//   high only while no entry is in progress; a finished result waits in
//   the output register while o_rsp.ready is low, and later events are
//   still taken; a later entry's result waits in S_DONE for the register.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   the block is idle, a rule for the user that the block does not
//   enforce. Synchronous reset clears the flags, the stored wake times
//   and the result, and loads the register reset values.
// ----------------------------------------------------------------------------
module cluster_last_core_power_election_unit #(
    parameter int CORES      = 4,
    parameter int NUM_STATES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [clpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [clpe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    clpe_req_if.sink                           i_req,
    clpe_rsp_if.source                         o_rsp
);

    // only cores reachable by the core field and the online mask take part
    localparam int NC = (CORES < 4) ? CORES : 4;
    localparam int CW = (NC > 1) ? $clog2(NC) : 1;
    localparam int UW = clpe_pkg::TIME_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIFF,
        S_CMP,
        S_DONE
    } t_state;

    // configuration registers
    logic                          r_cluster_enable;
    logic [3:0]                    r_online_mask;
    logic [clpe_pkg::SID_W-1:0]    r_state_id [4];
    logic [63:0]                   r_residency;

    // cluster state
    logic [NC-1:0]                 r_idle;
    logic [NC-1:0]                 r_ipi;
    logic [clpe_pkg::TIME_W-1:0]   r_wake [NC];

    // sequencer
    t_state                        r_state;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_me;
    logic [clpe_pkg::TIME_W-1:0]   r_now;
    logic [clpe_pkg::TIME_W-1:0]   r_earliest;
    logic                          r_any;
    logic                          r_fail;
    logic [UW-1:0]                 r_diff;
    logic                          r_cl_req;
    logic [clpe_pkg::IDX_W-1:0]    r_idx;
    logic [clpe_pkg::IDX_W-1:0]    r_lower;
    logic [clpe_pkg::RES_W-1:0]    r_res;
    logic [clpe_pkg::IDX_W-1:0]    r_gidx;
    logic                          r_dem;

    // output register
    logic                          r_out_valid;
    logic [clpe_pkg::IDX_W-1:0]    r_out_idx;
    logic [clpe_pkg::SID_W-1:0]    r_out_sid;
    logic                          r_out_dem;

    logic                          w_accept;
    logic                          w_core_ok;
    logic [CW-1:0]                 w_core;
    logic [clpe_pkg::IDX_W-1:0]    w_idx_c;
    logic [clpe_pkg::SID_W-1:0]    w_sid [8];
    logic [clpe_pkg::IDX_W-1:0]    w_lower;
    logic [clpe_pkg::RES_W-1:0]    w_res;
    logic [NC-1:0]                 w_online;
    logic [UW-1:0]                 w_a;
    logic [UW-1:0]                 w_b;
    logic [UW-1:0]                 n_sub;
    logic                          w_out_free;
    logic                          w_ok;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_enable <= 1'b1;
            r_online_mask    <= 4'hF;
            r_state_id[0]    <= '0;
            r_state_id[1]    <= '0;
            r_state_id[2]    <= '0;
            r_state_id[3]    <= '0;
            r_residency      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clpe_pkg::REG_CLUSTER_ENABLE: r_cluster_enable <= i_cfg_data[0];
                clpe_pkg::REG_ONLINE_MASK:    r_online_mask    <= i_cfg_data[3:0];
                clpe_pkg::REG_STATE_ID_1:     r_state_id[0]    <= i_cfg_data[31:0];
                clpe_pkg::REG_STATE_ID_2:     r_state_id[1]    <= i_cfg_data[31:0];
                clpe_pkg::REG_STATE_ID_3:     r_state_id[2]    <= i_cfg_data[31:0];
                clpe_pkg::REG_STATE_ID_4:     r_state_id[3]    <= i_cfg_data[31:0];
                clpe_pkg::REG_RESIDENCY:      r_residency      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // StateID per index, zero for WFI and for indexes without a register
    always_comb begin
        w_sid[0] = '0;
        w_sid[1] = r_state_id[0];
        w_sid[2] = r_state_id[1];
        w_sid[3] = r_state_id[2];
        w_sid[4] = r_state_id[3];
        w_sid[5] = '0;
        w_sid[6] = '0;
        w_sid[7] = '0;
    end

    // request decode
    assign w_accept  = i_req.valid && i_req.ready;
    assign w_core_ok = 32'(i_req.core) < CORES;
    assign w_core    = CW'(i_req.core);
    assign w_idx_c   = (32'(i_req.state_index) > NUM_STATES) ?
                       clpe_pkg::IDX_W'(NUM_STATES) : i_req.state_index;
    assign w_online  = NC'(r_online_mask);

    // deepest core-only state below the request
    always_comb begin
        w_lower = '0;
        for (int j = 1; j < 8; j++) begin
            if (clpe_pkg::IDX_W'(j) < w_idx_c && !clpe_pkg::is_cluster_id(w_sid[j])) begin
                w_lower = clpe_pkg::IDX_W'(j);
            end
        end
    end

    // residency of the requested index
    always_comb begin
        case (w_idx_c)
            3'd1:    w_res = r_residency[15:0];
            3'd2:    w_res = r_residency[31:16];
            3'd3:    w_res = r_residency[47:32];
            3'd4:    w_res = r_residency[63:48];
            default: w_res = '0;
        endcase
    end

    // shared subtractor: wake minimum, time gap, residency compare
    always_comb begin
        case (r_state)
            S_SCAN: begin
                w_a = {2'b00, r_wake[r_cnt]};
                w_b = {2'b00, r_earliest};
            end
            S_DIFF: begin
                w_a = {2'b00, r_earliest};
                w_b = {2'b00, r_now};
            end
            S_CMP: begin
                w_a = r_diff;
                w_b = {{(UW - clpe_pkg::RES_W){1'b0}}, r_res};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
        n_sub = w_a - w_b;
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_ok       = !r_fail && (!r_any || !n_sub[UW-1]);

    // sequencer, flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle      <= '0;
            r_ipi       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                r_wake[c] <= '0;
            end
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_core_ok) begin
                        case (i_req.op)
                            clpe_pkg::OP_EXIT:    r_idle[w_core] <= 1'b0;
                            clpe_pkg::OP_IPI_SET: r_ipi[w_core]  <= 1'b1;
                            clpe_pkg::OP_IPI_CLR: r_ipi[w_core]  <= 1'b0;
                            default: begin
                                r_idx    <= w_idx_c;
                                r_lower  <= w_lower;
                                r_res    <= w_res;
                                r_cl_req <= clpe_pkg::is_cluster_id(w_sid[w_idx_c]);
                                r_me     <= w_core;
                                r_now    <= i_req.now_us;
                                r_cnt    <= '0;
                                r_any    <= 1'b0;
                                r_fail   <= 1'b0;
                                if (w_idx_c == '0) begin
                                    r_gidx  <= '0;
                                    r_dem   <= 1'b0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_idle[w_core] <= 1'b1;
                                    r_wake[w_core] <= i_req.next_wake_us;
                                    r_state        <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // one core slot per cycle, only online cores checked
                    if (w_online[r_cnt]) begin
                        if (!r_idle[r_cnt] || (r_cnt != r_me && r_ipi[r_cnt])) begin
                            r_fail <= 1'b1;
                        end
                        if (!r_any || n_sub[UW-1]) begin
                            r_earliest <= r_wake[r_cnt];
                        end
                        r_any <= 1'b1;
                    end
                    if (r_cnt == CW'(NC - 1)) begin
                        r_state <= S_DIFF;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIFF: begin
                    r_diff  <= n_sub;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_cl_req && r_lower != '0 && (!r_cluster_enable || !w_ok)) begin
                        r_gidx <= r_lower;
                        r_dem  <= 1'b1;
                    end else begin
                        r_gidx <= r_idx;
                        r_dem  <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_gidx;
                        r_out_sid   <= w_sid[r_gidx];
                        r_out_dem   <= r_dem;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // channel drive
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_index = r_out_idx;
    assign o_rsp.suspend_param = r_out_sid;
    assign o_rsp.demoted       = r_out_dem;

    // a demoted grant always lands on a core-only state
    a_demoted_core_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.demoted) |->
        (o_rsp.granted_index != '0 && !clpe_pkg::is_cluster_id(o_rsp.suspend_param)))
        else $error("demoted grant is not a core-only state");

    // WFI grant carries no StateID and no demotion
    a_wfi_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.granted_index == '0) |->
        (o_rsp.suspend_param == '0 && !o_rsp.demoted))
        else $error("WFI grant with StateID or demotion");

    // granted index never passes the state count
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (32'(o_rsp.granted_index) <= NUM_STATES))
        else $error("granted index out of range");

endmodule

FILE: bench/cluster_last_core_power_election_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_last_core_power_election_unit_tb
// Self-checking bench for the cluster idle-entry election. Core events are
// sent from a queue with random gaps, and grants are taken with random
// stalls. A behavioral copy of the election predicts each grant, which is
// compared field by field. A directed opening covers the corner cases, then
// register settings change between phases of idle rounds and random events.
// ----------------------------------------------------------------------------
module cluster_last_core_power_election_unit_tb;

    localparam int N_CORES      = 4;
    localparam int N_STATES     = 4;
    localparam int SETTLE       = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 100;

    typedef struct {
        clpe_pkg::t_op                 op;
        logic [clpe_pkg::CORE_W-1:0]   core;
        logic [clpe_pkg::IDX_W-1:0]    state_index;
        logic [clpe_pkg::TIME_W-1:0]   now_us;
        logic [clpe_pkg::TIME_W-1:0]   next_wake_us;
        int                            gap;
    } t_pwr_event;

    typedef struct {
        logic [clpe_pkg::IDX_W-1:0] granted_index;
        logic [clpe_pkg::SID_W-1:0] suspend_param;
        logic                       demoted;
    } t_grant;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [clpe_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [clpe_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    clpe_req_if req_ch ();
    clpe_rsp_if rsp_ch ();

    cluster_last_core_power_election_unit #(
        .CORES      (N_CORES),
        .NUM_STATES (N_STATES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // predicted register and cluster state
    logic                              cfg_cluster_en;
    logic [N_CORES-1:0]                cfg_online;
    logic [clpe_pkg::SID_W-1:0]        sid_tab [1:N_STATES];
    logic [63:0]                       res_tab;
    logic [N_CORES-1:0]                idle_mask;
    logic [N_CORES-1:0]                ipi_pend;
    logic [clpe_pkg::TIME_W-1:0]       wake_tab [0:N_CORES-1];

    t_pwr_event            event_q [$];
    t_grant                grant_q [$];
    t_pwr_event            cur_ev;

    int                    wait_cnt;
    int                    stall_left;
    int                    dead_cycles;
    int                    n_queued;
    int                    n_events;
    int                    n_grants;
    int                    n_demoted;
    int                    n_cluster_won;
    int                    n_err;
    bit                    quiet;
    logic [clpe_pkg::TIME_W-1:0] base_us;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic powers_cluster(input logic [clpe_pkg::SID_W-1:0] sid);
        return sid[clpe_pkg::AFF_SHIFT +: 2] != 2'b00;
    endfunction

    // every online core idle, no foreign IPI, earliest wake far enough out
    function automatic logic collapse_ok(input logic [clpe_pkg::CORE_W-1:0] me,
                                         input logic [clpe_pkg::TIME_W-1:0] now,
                                         input logic [15:0] res);
        logic                        any;
        logic [clpe_pkg::TIME_W-1:0] earliest;
        longint                      gap;
        any      = 1'b0;
        earliest = '0;
        for (int c = 0; c < N_CORES; c++) begin
            if (cfg_online[c]) begin
                if (!idle_mask[c])
                    return 1'b0;
                if (c != me && ipi_pend[c])
                    return 1'b0;
                if (!any || wake_tab[c] < earliest)
                    earliest = wake_tab[c];
                any = 1'b1;
            end
        end
        if (!any)
            return 1'b1;
        gap = longint'({16'd0, earliest}) - longint'({16'd0, now});
        return gap >= longint'({48'd0, res});
    endfunction

    // update flags for one event and queue the grant an entry produces
    task automatic elect_idle_state(input t_pwr_event ev);
        int     idx;
        int     lower;
        t_grant g;
        idx = (ev.state_index > N_STATES) ? N_STATES : int'(ev.state_index);
        case (ev.op)
            clpe_pkg::OP_EXIT:    idle_mask[ev.core] = 1'b0;
            clpe_pkg::OP_IPI_SET: ipi_pend[ev.core] = 1'b1;
            clpe_pkg::OP_IPI_CLR: ipi_pend[ev.core] = 1'b0;
            clpe_pkg::OP_ENTER: begin
                g.granted_index = '0;
                g.suspend_param = '0;
                g.demoted       = 1'b0;
                if (idx != 0) begin
                    wake_tab[ev.core]  = ev.next_wake_us;
                    idle_mask[ev.core] = 1'b1;
                    g.granted_index    = clpe_pkg::IDX_W'(idx);
                    g.suspend_param    = sid_tab[idx];
                    if (powers_cluster(sid_tab[idx])) begin
                        lower = 0;
                        for (int j = idx - 1; j >= 1; j--)
                            if (lower == 0 && !powers_cluster(sid_tab[j]))
                                lower = j;
                        if (lower != 0 && (!cfg_cluster_en ||
                            !collapse_ok(ev.core, ev.now_us, res_tab[16*(idx-1) +: 16]))) begin
                            g.granted_index = clpe_pkg::IDX_W'(lower);
                            g.suspend_param = sid_tab[lower];
                            g.demoted       = 1'b1;
                            n_demoted++;
                        end else begin
                            n_cluster_won++;
                        end
                    end
                end
                grant_q.push_back(g);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        n_err++;
        $display("[%0t] grant %0d: %s expected 0x%0h got 0x%0h",
                 $time, n_grants, what, want, got);
    endtask

    function automatic logic [clpe_pkg::TIME_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[clpe_pkg::TIME_W-1:0];
    endfunction

    task automatic push_event(input clpe_pkg::t_op op,
                              input logic [clpe_pkg::CORE_W-1:0] core,
                              input logic [clpe_pkg::IDX_W-1:0] idx,
                              input logic [clpe_pkg::TIME_W-1:0] now,
                              input logic [clpe_pkg::TIME_W-1:0] wake);
        t_pwr_event ev;
        ev.op           = op;
        ev.core         = core;
        ev.state_index  = idx;
        ev.now_us       = now;
        ev.next_wake_us = wake;
        ev.gap          = quiet ? 0 : $urandom_range(0, 10);
        event_q.push_back(ev);
        n_queued++;
    endtask

    // register write, mirrored into the predicted configuration
    task automatic cfg_write(input logic [clpe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clpe_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            clpe_pkg::REG_CLUSTER_ENABLE: cfg_cluster_en = data[0];
            clpe_pkg::REG_ONLINE_MASK:    cfg_online = data[N_CORES-1:0];
            clpe_pkg::REG_STATE_ID_1:     sid_tab[1] = data[clpe_pkg::SID_W-1:0];
            clpe_pkg::REG_STATE_ID_2:     sid_tab[2] = data[clpe_pkg::SID_W-1:0];
            clpe_pkg::REG_STATE_ID_3:     sid_tab[3] = data[clpe_pkg::SID_W-1:0];
            clpe_pkg::REG_STATE_ID_4:     sid_tab[4] = data[clpe_pkg::SID_W-1:0];
            clpe_pkg::REG_RESIDENCY:      res_tab = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [3:0] online,
                              input logic [31:0] s1, input logic [31:0] s2,
                              input logic [31:0] s3, input logic [31:0] s4,
                              input logic [63:0] res);
        cfg_write(clpe_pkg::REG_CLUSTER_ENABLE, {63'd0, en});
        cfg_write(clpe_pkg::REG_ONLINE_MASK, {60'd0, online});
        cfg_write(clpe_pkg::REG_STATE_ID_1, {32'd0, s1});
        cfg_write(clpe_pkg::REG_STATE_ID_2, {32'd0, s2});
        cfg_write(clpe_pkg::REG_STATE_ID_3, {32'd0, s3});
        cfg_write(clpe_pkg::REG_STATE_ID_4, {32'd0, s4});
        cfg_write(clpe_pkg::REG_RESIDENCY, res);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config(input int phase);
        logic [clpe_pkg::SID_W-1:0] s [1:4];
        logic [63:0]                res;
        if (phase == 0) begin
            set_config(1'b0, 4'h0, '0, '0, '0, '0, '0);
        end else if (phase == 1) begin
            set_config(1'b1, 4'hF, '1, '1, '1, '1, '1);
        end else begin
            // shallow states mostly core-only, deep ones mostly cluster
            for (int i = 1; i <= 4; i++) begin
                s[i] = $urandom;
                if (i <= 2)
                    s[i][clpe_pkg::AFF_SHIFT +: 2] = ($urandom_range(0, 3) == 0) ?
                                                     2'($urandom_range(1, 3)) : 2'd0;
                else
                    s[i][clpe_pkg::AFF_SHIFT +: 2] = 2'($urandom_range(0, 3));
            end
            for (int i = 0; i < 4; i++)
                res[16*i +: 16] = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) :
                                                         16'($urandom_range(0, 65535));
            set_config($urandom_range(0, 4) != 0,
                       ($urandom_range(0, 2) != 0) ? 4'hF : 4'($urandom_range(0, 15)),
                       s[1], s[2], s[3], s[4], res);
        end
    endtask

    // all cores go idle in random order, then most of them wake again
    task automatic queue_round();
        logic [clpe_pkg::CORE_W-1:0] order [0:3];
        logic [clpe_pkg::CORE_W-1:0] tmp;
        logic [clpe_pkg::TIME_W-1:0] wake;
        int                          r;
        int                          ipi_core;
        for (int k = 0; k < 4; k++)
            order[k] = clpe_pkg::CORE_W'(k);
        for (int k = 3; k > 0; k--) begin
            r        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[r];
            order[r] = tmp;
        end
        base_us  = base_us + clpe_pkg::TIME_W'($urandom_range(1, 4000));
        ipi_core = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1;
        if (ipi_core >= 0)
            push_event(clpe_pkg::OP_IPI_SET, clpe_pkg::CORE_W'(ipi_core),
                       clpe_pkg::IDX_W'($urandom_range(0, 7)), rand48(), rand48());
        for (int k = 0; k < 4; k++) begin
            wake = base_us + clpe_pkg::TIME_W'($urandom_range(0, 140000));
            if ($urandom_range(0, 7) == 0)
                wake = wake - clpe_pkg::TIME_W'(30000);
            push_event(clpe_pkg::OP_ENTER, order[k],
                       ($urandom_range(0, 9) == 0) ? clpe_pkg::IDX_W'(0) :
                                                     clpe_pkg::IDX_W'($urandom_range(1, 4)),
                       base_us + clpe_pkg::TIME_W'(k), wake);
        end
        if (ipi_core >= 0)
            push_event(clpe_pkg::OP_IPI_CLR, clpe_pkg::CORE_W'(ipi_core),
                       clpe_pkg::IDX_W'($urandom_range(0, 7)), rand48(), rand48());
        for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 3) != 0)
                push_event(clpe_pkg::OP_EXIT, order[k],
                           clpe_pkg::IDX_W'($urandom_range(0, 7)), rand48(), rand48());
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (event_q.size() != 0 || req_ch.valid || grant_q.size() != 0);
    endtask

    task automatic quiesce();
        drain();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // event driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            wait_cnt     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                elect_idle_state(cur_ev);
                n_events++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (event_q.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (wait_cnt < event_q[0].gap) begin
                    wait_cnt     <= wait_cnt + 1;
                    req_ch.valid <= 1'b0;
                end else begin
                    cur_ev              = event_q.pop_front();
                    req_ch.op           <= cur_ev.op;
                    req_ch.core         <= cur_ev.core;
                    req_ch.state_index  <= cur_ev.state_index;
                    req_ch.now_us       <= cur_ev.now_us;
                    req_ch.next_wake_us <= cur_ev.next_wake_us;
                    req_ch.valid        <= 1'b1;
                    wait_cnt            <= 0;
                end
            end
        end
    end

    // grant monitor with random stalls
    always @(posedge i_clk) begin
        t_grant want;
        int     hold;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected grant, index", 64'd0,
                                64'(rsp_ch.granted_index));
            end else begin
                want = grant_q.pop_front();
                if (rsp_ch.granted_index !== want.granted_index)
                    report_mismatch("granted_index", 64'(want.granted_index),
                                    64'(rsp_ch.granted_index));
                if (rsp_ch.suspend_param !== want.suspend_param)
                    report_mismatch("suspend_param", 64'(want.suspend_param),
                                    64'(rsp_ch.suspend_param));
                if (rsp_ch.demoted !== want.demoted)
                    report_mismatch("demoted", 64'(want.demoted), 64'(rsp_ch.demoted));
            end
            n_grants++;
            hold = quiet ? 0 : $urandom_range(0, 10);
            stall_left   <= hold;
            rsp_ch.ready <= (hold == 0);
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            dead_cycles <= 0;
        end else if (dead_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, dead_cycles);
            $display("cluster_last_core_power_election_unit: mismatch");
            $finish;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        logic [clpe_pkg::TIME_W-1:0] t0;
        logic [clpe_pkg::TIME_W-1:0] tmax;
        bit                          paused;

        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = clpe_pkg::OP_ENTER;
        req_ch.core         = '0;
        req_ch.state_index  = '0;
        req_ch.now_us       = '0;
        req_ch.next_wake_us = '0;
        rsp_ch.ready        = 1'b0;

        cfg_cluster_en = 1'b1;
        cfg_online     = '1;
        for (int i = 1; i <= N_STATES; i++)
            sid_tab[i] = '0;
        res_tab   = '0;
        idle_mask = '0;
        ipi_pend  = '0;
        for (int c = 0; c < N_CORES; c++)
            wake_tab[c] = '0;
        n_queued      = 0;
        n_events      = 0;
        n_grants      = 0;
        n_demoted     = 0;
        n_cluster_won = 0;
        n_err         = 0;
        dead_cycles   = 0;
        quiet         = 1'b0;
        paused        = 1'b0;
        t0            = 48'd1_000_000;
        tmax          = '1;
        base_us       = rand48() >> 8;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two core-only and two cluster states
        set_config(1'b1, 4'hF, 32'h0000_0011, 32'h4000_0022, 32'h0100_0033,
                   32'hFF00_0044, {16'd5000, 16'd1000, 16'd200, 16'd100});
        push_event(clpe_pkg::OP_ENTER, 0, 0, t0, t0 + 100);             // wfi
        push_event(clpe_pkg::OP_ENTER, 0, 1, t0, t0 + 100);
        push_event(clpe_pkg::OP_ENTER, 1, 3, t0, t0 + 20000);           // others still busy
        push_event(clpe_pkg::OP_ENTER, 2, 2, t0, t0 + 20000);
        push_event(clpe_pkg::OP_IPI_SET, 2, 0, 0, 0);
        push_event(clpe_pkg::OP_ENTER, 3, 4, t0, t0 + 20000);           // ipi pending elsewhere
        push_event(clpe_pkg::OP_IPI_CLR, 2, 0, 0, 0);
        push_event(clpe_pkg::OP_ENTER, 0, 1, t0, t0 + 20000);
        push_event(clpe_pkg::OP_ENTER, 3, 7, t0, t0 + 20000);           // clamped, last core wins
        push_event(clpe_pkg::OP_ENTER, 2, 3, t0 + 19000, t0 + 20000);   // gap equals residency
        push_event(clpe_pkg::OP_ENTER, 2, 3, t0 + 19001, t0 + 20000);   // one short
        push_event(clpe_pkg::OP_ENTER, 1, 4, tmax, tmax);               // negative gap
        push_event(clpe_pkg::OP_ENTER, 1, 4, 0, tmax);
        push_event(clpe_pkg::OP_EXIT, 1, 7, tmax, tmax);
        push_event(clpe_pkg::OP_ENTER, 0, 3, t0, t0 + 20000);
        push_event(clpe_pkg::OP_ENTER, 3, 0, tmax, tmax);               // wfi, fields at max
        push_event(clpe_pkg::OP_IPI_SET, 1, 7, tmax, 0);
        push_event(clpe_pkg::OP_ENTER, 1, 4, t0, t0 + 20000);           // own ipi does not block
        push_event(clpe_pkg::OP_IPI_CLR, 1, 0, 0, 0);
        quiesce();
        // cluster states switched off, partial online set
        set_config(1'b0, 4'b0101, 32'h0000_0011, 32'h4000_0022, 32'h0100_0033,
                   32'hFF00_0044, {16'd5000, 16'd1000, 16'd200, 16'd100});
        push_event(clpe_pkg::OP_ENTER, 0, 4, t0, t0 + 20000);
        quiesce();
        // no online core at all
        set_config(1'b1, 4'h0, 32'h0000_0011, 32'h4000_0022, 32'h0100_0033,
                   32'hFF00_0044, {16'd5000, 16'd1000, 16'd200, 16'd100});
        push_event(clpe_pkg::OP_ENTER, 1, 4, t0, t0 + 10);
        quiesce();
        // shallowest state is a cluster state: nothing to fall back to
        set_config(1'b1, 4'hF, 32'h0200_0000, 32'h4000_0022, 32'h0100_0033,
                   32'hFF00_0044, {16'd5000, 16'd1000, 16'd200, 16'd100});
        push_event(clpe_pkg::OP_EXIT, 0, 0, 0, 0);
        push_event(clpe_pkg::OP_ENTER, 3, 1, t0, t0 + 20000);
        push_event(clpe_pkg::OP_ENTER, 3, 3, t0, t0 + 20000);

        // random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            random_config(phase);
            quiet    = (phase == 2 || phase == 5);
            n_queued = 0;
            while (n_queued < PHASE_EVENTS) begin
                // hold the sender once until every grant is back
                if (phase == 3 && !paused && n_queued >= PHASE_EVENTS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 7)
                    queue_round();
                else
                    push_event(clpe_pkg::t_op'($urandom_range(0, 3)),
                               clpe_pkg::CORE_W'($urandom_range(0, 3)),
                               clpe_pkg::IDX_W'($urandom_range(0, 7)), rand48(), rand48());
            end
        end
        quiesce();

        $display("%0d core events sent over %0d register settings, %0d grants checked",
                 n_events, PHASES + 4, n_grants);
        $display("%0d cluster requests demoted, %0d cluster states granted, %0d errors",
                 n_demoted, n_cluster_won, n_err);
        if (n_err == 0)
            $display("cluster_last_core_power_election_unit: match");
        else
            $display("cluster_last_core_power_election_unit: mismatch");
        $finish;
    end

endmodule
